@@ rtl/dam_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dam_pkg
// Shared types, codes and constants of the driver-assist mode controller.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int HIST_DEPTH = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX  = 2'd3;

  localparam logic [9:0] ACC_WINDOW_RST = 10'd500;
  localparam logic [3:0] SPEED_STEP_RST = 4'd5;
  localparam logic [7:0] SPEED_MIN_RST  = 8'd10;
  localparam logic [7:0] SPEED_MAX_RST  = 8'd50;

  // operations
  localparam logic OP_CHASSIS = 1'b0;
  localparam logic OP_FRAME   = 1'b1;

  // press sequence states
  localparam logic [1:0] STG_IDLE   = 2'd0;
  localparam logic [1:0] STG_FIRST  = 2'd1;
  localparam logic [1:0] STG_SECOND = 2'd2;

  // turn codes
  localparam logic [1:0] TURN_NONE    = 2'd0;
  localparam logic [1:0] TURN_LEFT    = 2'd1;
  localparam logic [1:0] TURN_RIGHT   = 2'd2;
  localparam logic [1:0] TURN_INVALID = 2'd3;

  // ego light codes
  localparam logic [1:0] LIGHT_NEUTRAL = 2'd1;
  localparam logic [1:0] LIGHT_LEFT    = 2'd2;
  localparam logic [1:0] LIGHT_RIGHT   = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [1:0] chassis_turn;
    logic       btn_cruise;
    logic       btn_cancel;
    logic       btn_set;
    logic       btn_resume;
    logic       driver_takeover;
    logic       lateral_takeover;
    logic       reversing;
    logic       lamp_left;
    logic       lamp_right;
  } dam_in_t;

  typedef struct packed {
    logic       auto_mode;
    logic       lat_auto_mode;
    logic       debug_flag;
    logic [7:0] target_speed;
    logic [1:0] light_request;
    logic [1:0] ego_light_code;
    logic [1:0] recent_turn;
    logic [7:0] press_balance;
  } dam_out_t;

endpackage
`default_nettype wire

@@ rtl/dam_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dam_if
// Channel interfaces: item input, result output and register write port.
// ----------------------------------------------------------------------------
interface dam_in_if;
  import dam_pkg::*;
  logic    valid;
  logic    ready;
  dam_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dam_out_if;
  import dam_pkg::*;
  logic     valid;
  logic     ready;
  dam_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dam_cfg_if;
  import dam_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/driver_assist_mode_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// driver_assist_mode_controller
// Cruise engage, set/resume target speed and turn lamp tracking per frame.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    dam_in_t (chassis item or vehicle frame)
//  out_ch   out  valid/ready    dam_out_t (one per vehicle frame)
//  cfg_ch   in   valid/ready    register index and write data
//
//  one item per cycle unless a frame waits on a stalled out_ch; an item waits
//  in the input register and its result is written to the output register as it leaves
//  the output register is refilled in the cycle it is taken, so a stalled
//  out_ch holds back the input register and then in_ch.ready
//  chassis items never wait on out_ch; cfg_ch is always ready
//  synchronous active-low reset clears all control state and the histories
// ----------------------------------------------------------------------------
module driver_assist_mode_controller (
  input  wire        clk,
  input  wire        rst_n,
  dam_in_if.sink     in_ch,
  dam_out_if.source  out_ch,
  dam_cfg_if.sink    cfg_ch
);
  import dam_pkg::*;

  logic [9:0] acc_window_r;
  logic [3:0] speed_step_r;
  logic [7:0] speed_min_r;
  logic [7:0] speed_max_r;

  logic    s1_valid_r;
  dam_in_t s1_data_r;

  logic     out_valid_r;
  dam_out_t out_r;

  logic [1:0]            press_stage_r, press_stage_nxt;
  logic [9:0]            release_count_r, release_count_nxt;
  logic                  auto_flag_r, auto_flag_nxt;
  logic                  lat_flag_r, lat_flag_nxt;
  logic                  debug_r, debug_nxt;
  logic [7:0]            balance_r, balance_nxt;
  logic                  plus_pending_r, plus_pending_nxt;
  logic                  minus_pending_r, minus_pending_nxt;
  logic [HIST_DEPTH-1:0] press_hist_r, press_hist_nxt;
  logic [1:0]            lamp_hist_r [HIST_DEPTH];
  logic [1:0]            lamp_hist_nxt [HIST_DEPTH];
  logic [1:0]            cached_turn_r;
  logic [7:0]            target_r, target_nxt;

  logic       adv;
  logic       in_xfer;
  logic [10:0] cnt;
  logic       press_bit;
  logic [1:0] lamp;
  logic [1:0] recent;
  logic [1:0] code;
  logic       quiet;
  logic signed [9:0] t;
  dam_out_t   res;

  assign adv = s1_valid_r &&
               (s1_data_r.operation == OP_CHASSIS || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  always_comb begin
    press_stage_nxt   = press_stage_r;
    release_count_nxt = release_count_r;
    auto_flag_nxt     = auto_flag_r;
    lat_flag_nxt      = lat_flag_r;
    debug_nxt         = debug_r;
    balance_nxt       = balance_r;
    plus_pending_nxt  = plus_pending_r;
    minus_pending_nxt = minus_pending_r;

    // cruise double press
    if (s1_data_r.btn_cruise) begin
      if (release_count_nxt != 10'd0) begin
        press_stage_nxt   = STG_SECOND;
        release_count_nxt = 10'd0;
      end
      if (press_stage_nxt == STG_IDLE) begin
        press_stage_nxt = STG_FIRST;
      end
    end
    cnt = {1'b0, release_count_nxt} +
          ((press_stage_nxt == STG_FIRST && !s1_data_r.btn_cruise) ? 11'd1 : 11'd0);
    if (cnt > {1'b0, acc_window_r}) begin
      press_stage_nxt = STG_IDLE;
      cnt             = 11'd0;
    end
    release_count_nxt = cnt[9:0];
    if (press_stage_nxt == STG_SECOND) begin
      press_stage_nxt = STG_IDLE;
      debug_nxt       = 1'b1;
      auto_flag_nxt   = 1'b1;
      lat_flag_nxt    = 1'b1;
      balance_nxt     = 8'd0;
    end
    if (s1_data_r.btn_cancel) begin
      debug_nxt     = 1'b0;
      auto_flag_nxt = 1'b0;
      balance_nxt   = 8'd0;
    end
    if (!auto_flag_nxt) begin
      lat_flag_nxt = 1'b0;
    end

    // set / resume
    press_bit = 1'b0;
    if (s1_data_r.btn_set) begin
      if (balance_nxt != 8'hFF) begin
        balance_nxt = balance_nxt + 8'd1;
      end
      plus_pending_nxt = 1'b1;
      press_bit        = 1'b1;
    end else if (s1_data_r.btn_resume) begin
      if (balance_nxt != 8'd0) begin
        balance_nxt = balance_nxt - 8'd1;
      end
      minus_pending_nxt = 1'b1;
      press_bit         = 1'b1;
    end
    press_hist_nxt[0] = press_bit;
    for (int i = 1; i < HIST_DEPTH; i++) begin
      press_hist_nxt[i] = press_hist_r[i-1];
    end

    // takeover and reversing
    if (s1_data_r.driver_takeover) begin
      auto_flag_nxt = 1'b0;
    end
    if (s1_data_r.lateral_takeover) begin
      lat_flag_nxt = 1'b0;
    end
    if (!lat_flag_nxt && auto_flag_nxt && s1_data_r.reversing) begin
      lat_flag_nxt = 1'b1;
    end

    // lamp history, newest at index 0
    lamp = s1_data_r.lamp_left ? TURN_LEFT :
           (s1_data_r.lamp_right ? TURN_RIGHT : TURN_NONE);
    lamp_hist_nxt[0] = lamp;
    for (int i = 1; i < HIST_DEPTH; i++) begin
      lamp_hist_nxt[i] = lamp_hist_r[i-1];
    end
    recent = TURN_NONE;
    for (int i = HIST_DEPTH - 1; i >= 0; i--) begin
      if (lamp_hist_nxt[i] != TURN_NONE) begin
        recent = lamp_hist_nxt[i];
      end
    end

    case (cached_turn_r)
      TURN_LEFT:  code = LIGHT_LEFT;
      TURN_RIGHT: code = LIGHT_RIGHT;
      default:    code = LIGHT_NEUTRAL;
    endcase

    // pending speed change once presses have settled
    quiet = (press_hist_nxt == '0);
    t = signed'({2'b00, target_r});
    if (quiet) begin
      if (plus_pending_nxt) begin
        t = t + signed'({6'd0, speed_step_r});
        plus_pending_nxt  = 1'b0;
        minus_pending_nxt = 1'b0;
      end else if (minus_pending_nxt) begin
        t = t - signed'({6'd0, speed_step_r});
        plus_pending_nxt  = 1'b0;
        minus_pending_nxt = 1'b0;
      end
    end
    if (t < signed'({2'b00, speed_min_r})) begin
      t = signed'({2'b00, speed_min_r});
    end else if (t > signed'({2'b00, speed_max_r})) begin
      t = signed'({2'b00, speed_max_r});
    end
    target_nxt = t[7:0];

    res.auto_mode      = auto_flag_nxt;
    res.lat_auto_mode  = lat_flag_nxt;
    res.debug_flag     = debug_nxt;
    res.target_speed   = target_nxt;
    res.light_request  = cached_turn_r;
    res.ego_light_code = code;
    res.recent_turn    = recent;
    res.press_balance  = balance_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_window_r <= ACC_WINDOW_RST;
      speed_step_r <= SPEED_STEP_RST;
      speed_min_r  <= SPEED_MIN_RST;
      speed_max_r  <= SPEED_MAX_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ACC_WINDOW: acc_window_r <= cfg_ch.data;
        CFG_SPEED_STEP: speed_step_r <= cfg_ch.data[3:0];
        CFG_SPEED_MIN:  speed_min_r  <= cfg_ch.data[7:0];
        CFG_SPEED_MAX:  speed_max_r  <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_data_r.operation == OP_FRAME) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_data_r.operation == OP_FRAME) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_stage_r   <= STG_IDLE;
      release_count_r <= 10'd0;
      auto_flag_r     <= 1'b0;
      lat_flag_r      <= 1'b0;
      debug_r         <= 1'b0;
      balance_r       <= 8'd0;
      plus_pending_r  <= 1'b0;
      minus_pending_r <= 1'b0;
      press_hist_r    <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        lamp_hist_r[i] <= TURN_NONE;
      end
      cached_turn_r   <= TURN_NONE;
      target_r        <= SPEED_MIN_RST;
    end else if (adv) begin
      if (s1_data_r.operation == OP_FRAME) begin
        press_stage_r   <= press_stage_nxt;
        release_count_r <= release_count_nxt;
        auto_flag_r     <= auto_flag_nxt;
        lat_flag_r      <= lat_flag_nxt;
        debug_r         <= debug_nxt;
        balance_r       <= balance_nxt;
        plus_pending_r  <= plus_pending_nxt;
        minus_pending_r <= minus_pending_nxt;
        press_hist_r    <= press_hist_nxt;
        lamp_hist_r     <= lamp_hist_nxt;
        target_r        <= target_nxt;
      end else begin
        cached_turn_r <= (s1_data_r.chassis_turn == TURN_INVALID) ?
                         TURN_NONE : s1_data_r.chassis_turn;
      end
    end
  end

  // a running release count only exists after a first press
  a_count_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (release_count_r != 10'd0) |-> (press_stage_r == STG_FIRST))
    else $error("release count running outside first-press stage");

  // a new result only comes from a vehicle frame leaving the input register
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && s1_data_r.operation == OP_FRAME))
    else $error("result without vehicle frame");

  // a chassis item never touches the mode flags
  a_chassis_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_data_r.operation == OP_CHASSIS) |=>
      ($stable(auto_flag_r) && $stable(lat_flag_r) && $stable(target_r)))
    else $error("chassis item changed mode state");

endmodule
`default_nettype wire
